// ===== rtl/prime_composite_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// prime_composite_classifier_core_defines
// Assertion macros used by the checker file of the classifier.
// ----------------------------------------------------------------------------
`ifndef PRIME_COMPOSITE_CLASSIFIER_CORE_DEFINES_SVH
`define PRIME_COMPOSITE_CLASSIFIER_CORE_DEFINES_SVH

// Concurrent assertion, switched off while reset is held.
`define PCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define PCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Widths, sequencer states and constants of the prime/composite classifier.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned NUM_W = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(5);
  localparam logic [WIDTH-1:0] DIVISOR_STEP  = WIDTH'(6);
  localparam logic [WIDTH-1:0] PAIR_OFFSET   = WIDTH'(2);
  localparam logic [WIDTH-1:0] THREE         = WIDTH'(3);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV3,
    ST_BOUND,
    ST_PAIR,
    ST_FINISH
  } state_e;

  // Divider control and results.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

endpackage

// ===== rtl/pcc_if.sv =====
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready stream interfaces for the classifier input and result channels.
// ----------------------------------------------------------------------------
interface pcc_in_if;
  logic                       valid;
  logic                       ready;
  logic [pcc_pkg::NUM_W-1:0]  number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface pcc_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  logic is_composite;

  modport source (output valid, output is_prime, output is_composite, input ready);
  modport sink   (input valid, input is_prime, input is_composite, output ready);
endinterface

// ===== rtl/pcc_div.sv =====
// ----------------------------------------------------------------------------
// pcc_div
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module pcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcc_pkg::div_req_t req_i,
  output pcc_pkg::div_rsp_t rsp_o
);
  import pcc_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            quo_q, quo_d;
  word_t            rem_q, rem_d;
  word_t            dvs_q, dvs_d;

  logic [WIDTH:0]   partial;
  logic [WIDTH:0]   diff;

  always_comb begin
    partial = {rem_q, quo_q[WIDTH-1]};
    diff    = partial - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // Subtract when the shifted remainder reaches the divisor.
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = partial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/prime_composite_classifier_core.sv =====
// ----------------------------------------------------------------------------
// prime_composite_classifier_core
// Values up to 3 and even values skip the divider and go straight to ST_FINISH.
// Otherwise trial divisions run one after another on the shared divider: one
// for 3, then two per 6k-1/6k+1 pair, until d > n / d or a divisor is found.
// One transaction at a time; the next is taken once the result is registered.
// Reset is asynchronous and active low; it clears the sequencer state and the output valid flag.
// ----------------------------------------------------------------------------
module prime_composite_classifier_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_in_if.sink    in_i,
  pcc_out_if.source out_o
);
  import pcc_pkg::*;

  state_e   state_q, state_d;
  word_t    n_q, n_d;
  word_t    d_q, d_d;
  logic     out_valid_q, out_valid_d;
  logic     prime_q, prime_d;
  logic     comp_q, comp_d;
  logic     res_prime_q, res_prime_d;
  logic     res_comp_q, res_comp_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [63:0] num_ext;
  word_t       num_in;

  assign num_ext = 64'(in_i.number);
  assign num_in  = num_ext[WIDTH-1:0];

  pcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    n_d              = n_q;
    d_d              = d_q;
    res_prime_d      = res_prime_q;
    res_comp_d       = res_comp_q;
    out_valid_d      = out_valid_q;
    prime_d          = prime_q;
    comp_d           = comp_q;
    div_req.start    = 1'b0;
    div_req.dividend = n_q;
    div_req.divisor  = d_q;
    in_i.ready       = (state_q == ST_IDLE);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          n_d         = num_in;
          res_prime_d = 1'b0;
          res_comp_d  = 1'b0;
          if (num_in <= WIDTH'(1)) begin
            state_d = ST_FINISH;
          end else if (num_in <= THREE) begin
            res_prime_d = 1'b1;
            state_d     = ST_FINISH;
          end else if (!num_in[0]) begin
            res_comp_d = 1'b1;
            state_d    = ST_FINISH;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = num_in;
            div_req.divisor  = THREE;
            state_d          = ST_DIV3;
          end
        end
      end
      ST_DIV3: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            res_comp_d = 1'b1;
            state_d    = ST_FINISH;
          end else begin
            d_d             = FIRST_DIVISOR;
            div_req.start   = 1'b1;
            div_req.divisor = FIRST_DIVISOR;
            state_d         = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        // d > n / d ends the search with no divisor found.
        if (div_rsp.done) begin
          if (d_q > div_rsp.quot) begin
            res_prime_d = 1'b1;
            state_d     = ST_FINISH;
          end else if (div_rsp.rem == '0) begin
            res_comp_d = 1'b1;
            state_d    = ST_FINISH;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = d_q + PAIR_OFFSET;
            state_d         = ST_PAIR;
          end
        end
      end
      ST_PAIR: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            res_comp_d = 1'b1;
            state_d    = ST_FINISH;
          end else begin
            d_d             = d_q + DIVISOR_STEP;
            div_req.start   = 1'b1;
            div_req.divisor = d_q + DIVISOR_STEP;
            state_d         = ST_BOUND;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the result register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          prime_d     = res_prime_q;
          comp_d      = res_comp_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    d_q         <= d_d;
    res_prime_q <= res_prime_d;
    res_comp_q  <= res_comp_d;
    prime_q     <= prime_d;
    comp_q      <= comp_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_prime     = prime_q;
  assign out_o.is_composite = comp_q;

endmodule

// ===== rtl/pcc_checker.sv =====
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "prime_composite_classifier_core_defines.svh"

module pcc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic is_prime_i,
  input logic is_composite_i
);

  `PCC_ASSERT(a_excl_class, clk_i, rst_ni, out_valid_i |-> !(is_prime_i && is_composite_i), "result both prime and composite")
  `PCC_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(is_prime_i) && $stable(is_composite_i)), "stalled result dropped or changed")
  `PCC_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "input taken while a transaction is in progress")
  `PCC_ASSERT(a_ready_on_result, clk_i, rst_ni, $rose(out_valid_i) |-> in_ready_i, "sequencer not idle after result load")

endmodule

bind prime_composite_classifier_core pcc_checker u_pcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .is_prime_i     (out_o.is_prime),
  .is_composite_i (out_o.is_composite)
);

// ===== dv/prime_composite_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// prime_composite_classifier_core_tb
// Drives numbers into the classifier and checks the prime and composite flags
// of every result against a trial-division predictor. A directed set covers
// zero, one, two, three, squares of primes, bit patterns and the largest
// 32-bit prime. Random numbers follow, mostly small, and large ones only where
// their smallest factor is small. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_composite_classifier_core_tb;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 3;
  localparam int unsigned RANDOM_NUMBERS = 76;
  localparam int unsigned CALM_TAIL      = 25;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned MAX_BIG_PAIRS  = 64;
  localparam int unsigned DRAIN_CYCLES   = 100;
  // The limit must outlast the largest 32-bit prime, which passes no transaction while it runs.
  localparam int unsigned WATCHDOG_LIMIT = 3_000_000;

  typedef logic [pcc_pkg::NUM_W-1:0] number_t;

  typedef struct {
    number_t     number;
    bit          is_prime;
    bit          is_composite;
    int unsigned pairs;
  } verdict_t;

  class primality_ledger;
    verdict_t    expected_verdicts[$];
    int unsigned faults;

    static function verdict_t classify(number_t number);
      longint unsigned n;
      longint unsigned d;
      longint unsigned lane_mask;
      verdict_t        v;
      lane_mask = (pcc_pkg::WIDTH >= 64) ? '1 : ((64'd1 << pcc_pkg::WIDTH) - 64'd1);
      n = 64'(number) & lane_mask;
      v.number   = number;
      v.is_prime = 1'b0;
      v.pairs    = 0;
      if (n <= 64'd1) begin
        v.is_prime = 1'b0;
      end else if (n <= 64'd3) begin
        v.is_prime = 1'b1;
      end else if (n % 64'd2 != 64'd0 && n % 64'd3 != 64'd0) begin
        v.is_prime = 1'b1;
        d = 64'd5;
        // d <= n / d keeps the bound free of overflow
        while (v.is_prime && d <= n / d) begin
          v.pairs++;
          if (n % d == 64'd0 || n % (d + 64'd2) == 64'd0) v.is_prime = 1'b0;
          d += 64'd6;
        end
      end
      v.is_composite = !v.is_prime && n > 64'd1;
      return v;
    endfunction

    function void note_number(number_t number);
      expected_verdicts.push_back(classify(number));
    endfunction

    function void check_verdict(logic is_prime, logic is_composite);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing pending: is_prime %b is_composite %b",
                 $time, is_prime, is_composite);
        faults++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (is_prime !== want.is_prime) begin
        $display("%0t: number %0d is_prime expected %0b actual %b",
                 $time, want.number, want.is_prime, is_prime);
        faults++;
      end
      if (is_composite !== want.is_composite) begin
        $display("%0t: number %0d is_composite expected %0b actual %b",
                 $time, want.number, want.is_composite, is_composite);
        faults++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pcc_in_if  in_if ();
  pcc_out_if out_if ();

  prime_composite_classifier_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  primality_ledger ledger = new();
  bit              idle_enable = 1'b1;
  bit              hold_results = 1'b0;
  int unsigned     quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Note inputs before checking results: each edge is handled in one place.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) ledger.note_number(in_if.number);
      if (out_if.valid && out_if.ready) ledger.check_verdict(out_if.is_prime, out_if.is_composite);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: one ready decision per step, then hold it for the chosen span.
  initial begin : result_sink
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_results) begin
        out_if.ready <= 1'b0;
        hold_results = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_number(number_t number);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.number <= number;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Mostly small numbers; large ones only where few trial pairs are needed.
  function automatic number_t pick_number();
    number_t  n;
    verdict_t v;
    case ($urandom_range(0, 3))
      0, 1:    n = $urandom_range(0, 1000);
      2:       n = $urandom_range(0, 65535);
      default: begin
        do begin
          n = $urandom();
          v = primality_ledger::classify(n);
        end while (v.pairs > MAX_BIG_PAIRS);
      end
    endcase
    return n;
  endfunction

  initial begin : stimulus
    number_t corner_numbers[$];
    corner_numbers = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
      32'd25, 32'd35, 32'd49, 32'd97, 32'd121, 32'd143, 32'd289, 32'd1009,
      32'd65521, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
      32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd4294967291
    };
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.number <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_numbers[i]) send_number(corner_numbers[i]);

    // Pause until every directed result is back; let the last one be noted first.
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.expected_verdicts.size() != 0) @(posedge clk_i);

    // Stall the result side while numbers keep coming.
    hold_results = 1'b1;
    for (int unsigned k = 0; k < RANDOM_NUMBERS; k++) begin
      if (k == RANDOM_NUMBERS - CALM_TAIL) idle_enable = 1'b0;
      send_number(pick_number());
    end
    in_if.valid <= 1'b0;
    @(posedge clk_i);

    while (ledger.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
